// ----- rtl/triangle_min_path_sum_macros.svh -----
// Assertion macros for the triangle minimum path sum RTL.
`ifndef TRIANGLE_MIN_PATH_SUM_MACROS_SVH
`define TRIANGLE_MIN_PATH_SUM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMPS_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tmps assertion failed");

// Next-cycle implication, disabled during reset.
`define TMPS_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tmps assertion failed");

`endif

// ----- rtl/tmps_pkg.sv -----
// Package: sizes, the queued operation type and the sum_min helper for the path sum block.
package tmps_pkg;

  localparam int MAX_ROWS      = 256;
  localparam int ELEMENT_WIDTH = 16;
  localparam int SUM_W         = 24;
  localparam int CFG_W         = 9;

  localparam int COL_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int RW    = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [COL_W-1:0] col_t;

  // One classified element on its way from the front to the back.
  typedef struct packed {
    sum_t elem;
    col_t col;
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_row;
  } op_t;

  // Smaller of two sums, compared as two's complement; ties keep a.
  function automatic sum_t sum_min(input sum_t a, input sum_t b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

endpackage

// ----- rtl/tmps_elem_if.sv -----
// Element channel: valid/ready handshake carrying one triangle element.
interface tmps_elem_if import tmps_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// ----- rtl/tmps_sum_if.sv -----
// Result channel: valid/ready handshake carrying one minimum path sum.
interface tmps_sum_if import tmps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] min_sum;

  modport source (output valid, output min_sum, input ready);
  modport sink   (input valid, input min_sum, output ready);
endinterface

// ----- rtl/tmps_queue.sv -----
// Two-entry queue of classified operations between front and back.
module tmps_queue import tmps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic valid,
  output op_t  pop_op
);

  op_t        ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign valid  = (cnt_r != 2'd0);
  assign pop_op = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/tmps_front.sv -----
// Front: row count register, row/column tracking and classification of each element.
module tmps_front import tmps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_row_count,
  tmps_elem_if.sink        in_chan,
  input  logic             q_full,
  output logic             q_push,
  output op_t              q_op
);

  logic [CFG_W-1:0] row_count_r;
  col_t             row_r, row_nxt;
  col_t             col_r, col_nxt;
  logic [RW-1:0]    cfg_ext, eff_rows, row_plus;
  logic signed [31:0] elem32;
  logic             acc;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && !q_full;
  assign q_push        = acc;

  always_comb begin
    cfg_ext = RW'(row_count_r);
    if (cfg_ext == '0) begin
      eff_rows = RW'(1);
    end else if (cfg_ext > RW'(MAX_ROWS)) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = cfg_ext;
    end
    row_plus = RW'(row_r) + RW'(1);
    elem32   = 32'(in_chan.element_value);

    q_op.elem      = elem32[SUM_W-1:0];
    q_op.col       = col_r;
    q_op.first_row = (row_r == '0);
    q_op.first_col = (col_r == '0);
    q_op.last_col  = (col_r == row_r);
    q_op.last_row  = (row_plus >= eff_rows);
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (acc) begin
      if (q_op.last_col) begin
        col_nxt = '0;
        row_nxt = q_op.last_row ? '0 : row_r + col_t'(1);
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_W'(1);
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (cfg_we) begin
        row_count_r <= cfg_row_count;
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ----- rtl/tmps_back.sv -----
// Back: row store read-modify-write, left parent, running minimum and result register.
module tmps_back import tmps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  op_t        q_op,
  output logic       q_pop,
  tmps_sum_if.source out_chan
);

  sum_t mem [MAX_ROWS];

  logic a_valid_r;
  op_t  a_op_r;
  sum_t rd_data_r;
  logic fwd_r;
  sum_t fwd_data_r;

  sum_t held_r, held_nxt;
  sum_t run_min_r, run_min_nxt;
  logic out_valid_r, out_valid_nxt;
  sum_t out_sum_r;

  sum_t above, fresh, row_min;
  logic a_end, exec;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.min_sum = out_sum_r;

  assign a_end = a_op_r.last_col && a_op_r.last_row;
  assign exec  = a_valid_r && (!a_end || !out_valid_r || out_chan.ready);
  assign q_pop = q_valid && (!a_valid_r || exec);
  assign above = fwd_r ? fwd_data_r : rd_data_r;

  always_comb begin
    held_nxt = held_r;
    if (a_op_r.first_row) begin
      fresh = a_op_r.elem;
    end else if (a_op_r.first_col) begin
      fresh    = a_op_r.elem + above;
      held_nxt = above;
    end else if (!a_op_r.last_col) begin
      fresh    = a_op_r.elem + sum_min(held_r, above);
      held_nxt = above;
    end else begin
      fresh = a_op_r.elem + held_r;
    end
    row_min = sum_min(run_min_r, fresh);

    run_min_nxt   = run_min_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (exec) begin
      if (a_end) begin
        held_nxt      = '0;
        run_min_nxt   = SUM_MAX;
        out_valid_nxt = 1'b1;
      end else if (a_op_r.last_row) begin
        run_min_nxt = row_min;
      end
    end else begin
      held_nxt = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      held_r      <= '0;
      run_min_r   <= SUM_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        a_valid_r <= 1'b1;
        fwd_r     <= exec && (a_op_r.col == q_op.col);
      end else if (exec) begin
        a_valid_r <= 1'b0;
      end
      held_r      <= held_nxt;
      run_min_r   <= run_min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and row store
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op_r     <= q_op;
      rd_data_r  <= mem[q_op.col];
      fwd_data_r <= fresh;
    end
    if (exec) begin
      mem[a_op_r.col] <= fresh;
      if (a_end) begin
        out_sum_r <= row_min;
      end
    end
  end

endmodule

// ----- rtl/triangle_min_path_sum.sv -----
// Top level of the triangle minimum path sum block.
// Elements of a number triangle enter one item per clock while in_chan.ready
// is high, in row-major order (row r has r+1 elements); cfg_row_count sets
// the rows per triangle, with zero taken as one and values above 256 taken
// as 256, and it may be written only while the block is idle. The block
// keeps one row of best path sums in a 256 x 24 bit row store and, on the
// last element of the last row, gives one item carrying the smallest sum of
// that row, then starts afresh. Every other element gives no result.
// Sustained rate is one element per cycle while the sink takes results: each
// element costs one read and one write of the single row store, split over a
// read cycle and an execute cycle, with a bypass for the one case where an
// element reads the entry its predecessor is writing. in_chan.ready drops
// only when the two-entry queue is full, which happens when the result
// register is held by a stalled sink. The row store needs no clearing: each
// entry is written before it is used. Sums wrap at 24 bits.
module triangle_min_path_sum import tmps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_row_count,
  tmps_elem_if.sink        in_chan,
  tmps_sum_if.source       out_chan
);

`include "triangle_min_path_sum_macros.svh"

  // front -> queue
  logic q_push;
  logic q_full;
  op_t  push_op;

  // queue -> back
  logic q_valid;
  logic q_pop;
  op_t  pop_op;

  // Front classifies each item by its place in the triangle.
  tmps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_row_count (cfg_row_count),
    .in_chan       (in_chan),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (push_op)
  );

  // Short queue lets the front keep taking items while the back waits.
  tmps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_op  (pop_op)
  );

  // Back does the row store update and owns the result register.
  tmps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_op     (pop_op),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // Back never pops an empty queue.
  `TMPS_ASSERT_NOW(a_pop_nonempty, clk, rst_n, q_pop, q_valid)
  // Row zero holds a single element, so it is both first and last column.
  `TMPS_ASSERT_NOW(a_row0_single, clk, rst_n, q_push && push_op.first_row,
                   push_op.first_col && push_op.last_col)
  // A push without a pop leaves something queued.
  `TMPS_ASSERT_NEXT(a_push_holds, clk, rst_n, q_push && !q_pop, q_valid)

endmodule
